/* design/tmb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmb_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package tmb_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_TILE_DEF   = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 11;

    localparam int PIX_W    = 8;
    localparam int STAT_W   = 2;
    localparam int OPOS_W   = 10;
    localparam int M_DATA_W = 32;
    localparam int M_PAD_W  = M_DATA_W - PIX_W - 2 * OPOS_W;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TILE_SIZE    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_ROW   = 3'd4;

    localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [10:0] IMAGE_HEIGHT_RST = 11'd480;
    localparam logic [4:0]  TILE_SIZE_RST    = 5'd8;
    localparam logic [7:0]  THRESHOLD_RST    = 8'd128;
    localparam logic [10:0] ACTIVE_ROW_RST   = 11'd100;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    localparam logic [STAT_W-1:0] STAT_PUSH_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PIXEL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_READY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OVERRUN   = 2'd3;

    localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

    typedef struct packed {
        logic load_item;
        logic div_start;
        logic sum_rd;
        logic push_wr;
        logic fin_init;
        logic fin_rd;
        logic fin_mul;
        logic fin_cmp;
        logic band_done;
        logic bits_rd;
        logic pull_out;
        logic set_reject;
        logic emit;
    } tmb_cmd_t;

    typedef struct packed {
        logic item_pull;
        logic br_full;
        logic br_empty;
        logic div_done;
        logic band_end;
        logic fin_more;
        logic out_free;
    } tmb_stat_t;

endpackage

/* design/tile_mean_binarizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_mean_binarizer
// tile mean threshold binarizer over a raster pixel stream, two bit banks
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one command per transfer, s_tuser = cmd (0 push, 1 pull),
//   s_tdata = grey pixel for a push. m_ channel: one result per command,
//   m_tuser = status, m_tdata = pixel, row, column, m_tlast = image's last pixel.
//   cfg_wr_en/cfg_addr/cfg_wdata write the size, tile, threshold and active
//   row registers while no command is in progress.
// timing:
//   a push or pull that is carried out shows its result on m_tvalid after the
//   bit-serial divider has mapped the column to a tile and the row to its place
//   in the band; the block is ready for the next command in the cycle after the
//   result is loaded into the output register. a rejected push or a not-ready
//   pull skips the divider. the push that ends a band also runs the threshold
//   sweep over the tile sum memory, a read, multiply and compare step per tile.
//   one command at a time.
// reset and stall:
//   reset restores the register defaults and empties both bands; the sum and
//   bit memories are not cleared. a finished result waits in the output
//   register while m_tready is low, and the next command is accepted and worked
//   meanwhile; its result waits until the output register is free.
// ----------------------------------------------------------------------------
module tile_mean_binarizer import tmb_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_TILE   = MAX_TILE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // pixel_in
    input  logic [0:0]            s_tuser,   // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // pixel_out, out_row, out_col, zero pad
    output logic [STAT_W-1:0]     m_tuser,   // status
    output logic                  m_tlast
);

    tmb_cmd_t  cmd;
    tmb_stat_t stat;

    tmb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    tmb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_TILE   (MAX_TILE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* design/tmb_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmb_div
// two-lane bit-serial restoring divider by the tile size, one bit per cycle
// ----------------------------------------------------------------------------
module tmb_div import tmb_pkg::*; #(
    parameter int DW = 10,
    parameter int TW = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend_a,
    input  logic [DW-1:0] dividend_b,
    input  logic [TW-1:0] divisor,
    output logic [DW-1:0] quot_a,
    output logic [TW-1:0] rem_a,
    output logic [TW-1:0] rem_b,
    output logic          done
);

    localparam int CNTW = $clog2(DW);

    logic            busy_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [DW-1:0]   q_reg [2];
    logic [TW-1:0]   r_reg [2];
    logic [DW-1:0]   q_next [2];
    logic [TW-1:0]   r_next [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            logic [TW:0] trial;
            trial = {r_reg[i], q_reg[i][DW-1]};
            if (trial >= {1'b0, divisor}) begin
                r_next[i] = TW'(trial - {1'b0, divisor});
                q_next[i] = {q_reg[i][DW-2:0], 1'b1};
            end else begin
                r_next[i] = trial[TW-1:0];
                q_next[i] = {q_reg[i][DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNTW'(DW - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg[0] <= dividend_a;
            q_reg[1] <= dividend_b;
            r_reg[0] <= '0;
            r_reg[1] <= '0;
        end else if (busy_reg) begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quot_a = q_reg[0];
    assign rem_a  = r_reg[0];
    assign rem_b  = r_reg[1];
    assign done   = !busy_reg;

endmodule

/* design/tmb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmb_datapath
// config registers, positions, tile sum and tile bit memories, result regs
// ----------------------------------------------------------------------------
module tmb_datapath import tmb_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_TILE   = MAX_TILE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [PIX_W-1:0]      s_tdata,
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic [STAT_W-1:0]     m_tuser,
    output logic                  m_tlast,
    input  tmb_cmd_t              cmd,
    output tmb_stat_t             stat
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int TW   = $clog2(MAX_TILE + 1);
    localparam int DW   = (CW > RW) ? CW : RW;
    localparam int WV   = CW + 1;
    localparam int HV   = RW + 1;
    localparam int SW   = PIX_W + 2 * $clog2(MAX_TILE);
    localparam int TRW  = PIX_W + TW;
    localparam int PW   = PIX_W + 2 * TW;
    localparam int FSW  = CW + 2;

    // config
    logic [10:0]        width_cfg_reg;
    logic [10:0]        height_cfg_reg;
    logic [4:0]         tile_cfg_reg;
    logic [7:0]         thr_reg;
    logic [10:0]        ars_reg;

    // control state
    logic [CW-1:0]      in_col_reg, drain_col_reg;
    logic [RW-1:0]      in_row_reg, drain_row_reg;
    logic [1:0]         br_reg;
    logic               fill_bank_reg;
    logic               m_valid_reg;

    // item and work registers
    logic               item_cmd_reg;
    logic [PIX_W-1:0]   item_pix_reg;
    logic [CW-1:0]      col_reg;
    logic [SW-1:0]      sum_rd_reg;
    logic               bit_rd_reg;
    logic [TRW-1:0]     thr_rows_reg;
    logic [TW-1:0]      cols_reg;
    logic [PW-1:0]      prod_reg;
    logic [CW-1:0]      fin_t_reg;
    logic [FSW-1:0]     fin_start_reg;

    // result and output registers
    logic [STAT_W-1:0]  res_status_reg, out_status_reg;
    logic [PIX_W-1:0]   res_pix_reg, out_pix_reg;
    logic [OPOS_W-1:0]  res_row_reg, out_row_reg;
    logic [OPOS_W-1:0]  res_col_reg, out_col_reg;
    logic               res_last_reg, out_last_reg;

    // memories
    logic [SW-1:0]      sum_mem [MAX_WIDTH];
    logic               bits_mem [2 * MAX_WIDTH];

    logic [WV-1:0]      w_used, w_m1;
    logic [HV-1:0]      h_used, h_m1;
    logic [TW-1:0]      ts_used, ts_m1;
    logic               item_pull;
    logic [CW-1:0]      pos_col, col_sel;
    logic [RW-1:0]      pos_row;
    logic               last_row, row_end, rin_last, first_px;
    logic [DW-1:0]      quot_a;
    logic [TW-1:0]      rem_a, rem_b, rows;
    logic [CW-1:0]      t_idx;
    logic               div_done;
    logic               bank_rd;
    logic [FSW-1:0]     fin_left;
    logic [TW-1:0]      cols_next;
    logic [SW-1:0]      sum_next;
    logic               pull_white;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= IMAGE_WIDTH_RST;
            height_cfg_reg <= IMAGE_HEIGHT_RST;
            tile_cfg_reg   <= TILE_SIZE_RST;
            thr_reg        <= THRESHOLD_RST;
            ars_reg        <= ACTIVE_ROW_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_wdata;
                REG_TILE_SIZE:    tile_cfg_reg   <= cfg_wdata[4:0];
                REG_THRESHOLD:    thr_reg        <= cfg_wdata[7:0];
                REG_ACTIVE_ROW:   ars_reg        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // saturated sizes
    always_comb begin
        if (width_cfg_reg == '0) begin
            w_used = WV'(1);
        end else if (32'(width_cfg_reg) > MAX_WIDTH) begin
            w_used = WV'(MAX_WIDTH);
        end else begin
            w_used = WV'(width_cfg_reg);
        end
        if (height_cfg_reg == '0) begin
            h_used = HV'(1);
        end else if (32'(height_cfg_reg) > MAX_HEIGHT) begin
            h_used = HV'(MAX_HEIGHT);
        end else begin
            h_used = HV'(height_cfg_reg);
        end
        if (tile_cfg_reg == '0) begin
            ts_used = TW'(1);
        end else if (32'(tile_cfg_reg) > MAX_TILE) begin
            ts_used = TW'(MAX_TILE);
        end else begin
            ts_used = TW'(tile_cfg_reg);
        end
    end

    assign w_m1  = w_used - WV'(1);
    assign h_m1  = h_used - HV'(1);
    assign ts_m1 = ts_used - TW'(1);

    assign item_pull = (item_cmd_reg == CMD_PULL);
    assign pos_col   = item_pull ? drain_col_reg : in_col_reg;
    assign pos_row   = item_pull ? drain_row_reg : in_row_reg;
    assign col_sel   = ({1'b0, pos_col} < w_used) ? pos_col : w_m1[CW-1:0];
    assign last_row  = ({1'b0, pos_row} >= h_m1);
    assign row_end   = ({1'b0, col_reg} >= w_m1);

    tmb_div #(
        .DW (DW),
        .TW (TW)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (cmd.div_start),
        .dividend_a (DW'(col_sel)),
        .dividend_b (DW'(pos_row)),
        .divisor    (ts_used),
        .quot_a     (quot_a),
        .rem_a      (rem_a),
        .rem_b      (rem_b),
        .done       (div_done)
    );

    assign t_idx      = quot_a[CW-1:0];
    assign rin_last   = (rem_b == ts_m1);
    assign first_px   = (rem_a == '0) && (rem_b == '0);
    assign rows       = rem_b + TW'(1);
    assign bank_rd    = (br_reg == 2'd1) ? ~fill_bank_reg : fill_bank_reg;
    assign fin_left   = FSW'(w_used) - fin_start_reg;
    assign cols_next  = (fin_left > FSW'(ts_used)) ? ts_used : fin_left[TW-1:0];
    assign sum_next   = first_px ? SW'(item_pix_reg) : sum_rd_reg + SW'(item_pix_reg);
    assign pull_white = bit_rd_reg && (32'(drain_row_reg) >= 32'(ars_reg));

    // tile sum memory
    always_ff @(posedge aclk) begin
        if (cmd.sum_rd || cmd.fin_rd) begin
            sum_rd_reg <= sum_mem[cmd.fin_rd ? fin_t_reg : t_idx];
        end
        if (cmd.push_wr) begin
            sum_mem[t_idx] <= sum_next;
        end
    end

    // tile bit memory, two banks
    always_ff @(posedge aclk) begin
        if (cmd.bits_rd) begin
            bit_rd_reg <= bits_mem[{bank_rd, t_idx}];
        end
        if (cmd.fin_cmp) begin
            bits_mem[{fill_bank_reg, fin_t_reg}] <= (32'(sum_rd_reg) >= 32'(prod_reg));
        end
    end

    // positions and band bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            drain_col_reg <= '0;
            drain_row_reg <= '0;
            br_reg        <= '0;
            fill_bank_reg <= 1'b0;
        end else begin
            if (cmd.push_wr) begin
                if (row_end) begin
                    in_col_reg <= '0;
                    in_row_reg <= last_row ? '0 : in_row_reg + RW'(1);
                end else begin
                    in_col_reg <= col_reg + CW'(1);
                end
            end
            if (cmd.pull_out) begin
                if (row_end) begin
                    drain_col_reg <= '0;
                    drain_row_reg <= last_row ? '0 : drain_row_reg + RW'(1);
                end else begin
                    drain_col_reg <= col_reg + CW'(1);
                end
            end
            if (cmd.band_done) begin
                br_reg        <= br_reg + 2'd1;
                fill_bank_reg <= ~fill_bank_reg;
            end else if (cmd.pull_out && row_end && (rin_last || last_row)) begin
                br_reg <= br_reg - 2'd1;
            end
        end
    end

    // item, band sweep and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_cmd_reg <= s_tuser[0];
            item_pix_reg <= s_tdata;
        end
        if (cmd.div_start) begin
            col_reg <= col_sel;
        end
        if (cmd.fin_init) begin
            thr_rows_reg  <= TRW'(thr_reg) * TRW'(rows);
            fin_t_reg     <= '0;
            fin_start_reg <= '0;
        end
        if (cmd.fin_rd) begin
            cols_reg <= cols_next;
        end
        if (cmd.fin_mul) begin
            prod_reg <= PW'(thr_rows_reg) * PW'(cols_reg);
        end
        if (cmd.fin_cmp) begin
            fin_t_reg     <= fin_t_reg + CW'(1);
            fin_start_reg <= fin_start_reg + FSW'(ts_used);
        end
        if (cmd.set_reject || cmd.push_wr) begin
            res_status_reg <= cmd.push_wr ? STAT_PUSH_OK
                            : (item_pull ? STAT_NOT_READY : STAT_OVERRUN);
            res_pix_reg    <= PIX_BLACK;
            res_row_reg    <= '0;
            res_col_reg    <= '0;
            res_last_reg   <= 1'b0;
        end
        if (cmd.pull_out) begin
            res_status_reg <= STAT_PIXEL;
            res_pix_reg    <= pull_white ? PIX_WHITE : PIX_BLACK;
            res_row_reg    <= OPOS_W'(32'(drain_row_reg));
            res_col_reg    <= OPOS_W'(32'(col_reg));
            res_last_reg   <= row_end && last_row;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_status_reg <= res_status_reg;
            out_pix_reg    <= res_pix_reg;
            out_row_reg    <= res_row_reg;
            out_col_reg    <= res_col_reg;
            out_last_reg   <= res_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {M_PAD_W'(0), out_col_reg, out_row_reg, out_pix_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    assign stat.item_pull = item_pull;
    assign stat.br_full   = (br_reg >= 2'd2);
    assign stat.br_empty  = (br_reg == 2'd0);
    assign stat.div_done  = div_done;
    assign stat.band_end  = row_end && (rin_last || last_row);
    assign stat.fin_more  = (32'(fin_start_reg) < 32'(w_used));
    assign stat.out_free  = !m_valid_reg || m_tready;

`ifndef ASSERT_OFF
    a_bands_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        br_reg <= 2'd2)
        else $error("more than two completed bands");

    a_no_pull_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pull_out |-> br_reg != 2'd0)
        else $error("pixel drained with no completed band");

    a_plain_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_status_reg != STAT_PIXEL) |-> (m_tdata == '0 && !m_tlast))
        else $error("non-pixel result carries data");

    a_binary_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_status_reg == STAT_PIXEL)
        |-> (out_pix_reg == PIX_WHITE || out_pix_reg == PIX_BLACK))
        else $error("output pixel not binary");
`endif

endmodule

/* design/tmb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmb_ctrl
// sequencer for push, pull, band finish sweep and result hand-off
// ----------------------------------------------------------------------------
module tmb_ctrl import tmb_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output tmb_cmd_t  cmd,
    input  tmb_stat_t stat
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_PUSH_WR,
        ST_FIN_RD,
        ST_FIN_MUL,
        ST_FIN_CMP,
        ST_PULL_OUT,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if ((!stat.item_pull && stat.br_full) || (stat.item_pull && stat.br_empty)) begin
                    cmd.set_reject = 1'b1;
                    state_next     = ST_EMIT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    if (stat.item_pull) begin
                        cmd.bits_rd = 1'b1;
                        state_next  = ST_PULL_OUT;
                    end else begin
                        cmd.sum_rd = 1'b1;
                        state_next = ST_PUSH_WR;
                    end
                end
            end
            ST_PUSH_WR: begin
                cmd.push_wr = 1'b1;
                if (stat.band_end) begin
                    cmd.fin_init = 1'b1;
                    state_next   = ST_FIN_RD;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_FIN_RD: begin
                if (stat.fin_more) begin
                    cmd.fin_rd = 1'b1;
                    state_next = ST_FIN_MUL;
                end else begin
                    cmd.band_done = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_FIN_MUL: begin
                cmd.fin_mul = 1'b1;
                state_next  = ST_FIN_CMP;
            end
            ST_FIN_CMP: begin
                cmd.fin_cmp = 1'b1;
                state_next  = ST_FIN_RD;
            end
            ST_PULL_OUT: begin
                cmd.pull_out = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule
